// ----- hw/rtl/jet_pkg.sv -----
// shared types and constants of the julia escape-time engine
// field widths, register indexes, reset values and the control/status structs
// no dependencies
`default_nettype none

package jet_pkg;

  localparam int INDEX_BITS    = 12;
  localparam int COUNT_BITS    = 16;
  localparam int COORD_BITS    = 32;
  localparam int STEP_BITS     = 31;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEFT_EDGE   = 3'd0,
    REG_BOTTOM_EDGE = 3'd1,
    REG_X_STEP      = 3'd2,
    REG_Y_STEP      = 3'd3,
    REG_MAX_ITER    = 3'd4,
    REG_C_REAL      = 3'd5,
    REG_C_IMAG      = 3'd6
  } cfg_reg_e;

  localparam logic signed [COORD_BITS-1:0] LEFT_EDGE_RST   = -32'sd536870912;
  localparam logic signed [COORD_BITS-1:0] BOTTOM_EDGE_RST = -32'sd536870912;
  localparam logic [STEP_BITS-1:0]         X_STEP_RST      = 31'd1048576;
  localparam logic [STEP_BITS-1:0]         Y_STEP_RST      = 31'd1048576;
  localparam logic [COUNT_BITS-1:0]        MAX_ITER_RST    = 16'd255;
  localparam logic signed [COORD_BITS-1:0] C_REAL_RST      = 32'sd0;
  localparam logic signed [COORD_BITS-1:0] C_IMAG_RST      = 32'sd0;

  typedef struct packed {
    logic [INDEX_BITS-1:0] column;
    logic [INDEX_BITS-1:0] row;
  } jet_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_re;
    logic signed [COORD_BITS-1:0] start_im;
    logic [COUNT_BITS-1:0]        escape_count;
  } jet_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // register pixel offset products
    logic init;       // form start point, clear count
    logic mul;        // register squares and cross product
    logic advance;    // take the next z
    logic count_inc;  // one more iteration completed
  } jet_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic limit_zero;
    logic escape;
    logic last;
  } jet_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/julia_escape_time.sv -----
// top level of the julia escape-time engine
// joins jet_ctrl and jet_dp; depends on jet_pkg
//
// usage:
//   pixel channel: drive pixel_i (column, row) and raise start; the beat is
//   taken at a rising edge with start high and busy low. one pixel at a time.
//   result channel: done_o is high for exactly one cycle with result_o
//   (start point and escape count). the receiver cannot stall, so the result
//   must be taken in that cycle.
//   config channel: cfg_valid_i/cfg_ready_o with a register index and data;
//   cfg_ready_o is always high. write only while busy is low. unknown
//   indexes are dropped.
// sequence:
//   after the accepting edge the engine forms the start point, then iterates
//   until escape or the limit; a zero limit goes from setup straight to the
//   result beat. each iteration first registers the three 32x32 products,
//   then forms the next z and, except on the first pass, tests the squares
//   of the current z against 4. a new pixel can be taken the cycle after
//   done_o.
// reset: configuration returns to its defaults, the sequencer goes idle.
`default_nettype none

module julia_escape_time #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire jet_pkg::jet_in_t                   pixel_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [jet_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [jet_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic                                    done_o,
  output jet_pkg::jet_out_t                       result_o
);

  jet_pkg::jet_cmd_t cmd;
  jet_pkg::jet_sts_t sts;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  jet_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  jet_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pixel_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

  // an accepted pixel goes through setup before any result
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("accepted pixel did not enter setup");

  // the result beat ends the item
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("engine still busy after result beat");

  // products are registered only after a start point exists
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mul || cmd.advance || cmd.count_inc) |-> busy && !done_o)
    else $error("datapath command outside an item");

endmodule

`default_nettype wire

// ----- hw/rtl/jet_ctrl.sv -----
// sequencer of the julia escape-time engine
// steps the datapath through setup and the multiply/update loop
// depends on jet_pkg
`default_nettype none

module jet_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire jet_pkg::jet_sts_t sts_i,
  output jet_pkg::jet_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_STEP = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   first_q, first_d;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        first_d    = 1'b1;
        state_d    = sts_i.limit_zero ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_STEP;
      end
      ST_STEP: begin
        // the start point itself is never tested for escape
        if (first_q) begin
          cmd_o.advance = 1'b1;
          first_d       = 1'b0;
          state_d       = ST_MUL;
        end else if (sts_i.escape) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.count_inc = 1'b1;
          if (sts_i.last) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ----- hw/rtl/jet_dp.sv -----
// datapath of the julia escape-time engine
// configuration registers, start point, iteration registers and escape test
// depends on jet_pkg
`default_nettype none

module jet_dp #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [jet_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [jet_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire jet_pkg::jet_in_t                   pixel_i,
  input  wire jet_pkg::jet_cmd_t                  cmd_i,
  output jet_pkg::jet_sts_t                       sts_o,
  output jet_pkg::jet_out_t                       result_o
);

  localparam int CW = jet_pkg::COORD_BITS;
  localparam int NW = jet_pkg::COUNT_BITS;
  localparam int PW = jet_pkg::INDEX_BITS + jet_pkg::STEP_BITS;
  localparam int WW = 2 * CW;
  localparam int ThrShift = 2 * FRAC_BITS + 2;
  localparam logic EscEn = (ThrShift < WW);
  localparam logic [WW-1:0] Thresh = EscEn ? (64'd1 << ThrShift) : 64'd0;
  localparam logic signed [WW-1:0] SatMax = 64'sd2147483647;
  localparam logic signed [WW-1:0] SatMin = -64'sd2147483648;

  function automatic logic signed [CW-1:0] sat32(input logic signed [WW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[CW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // configuration
  logic signed [CW-1:0]                left_q, bottom_q, c_re_q, c_im_q;
  logic [jet_pkg::STEP_BITS-1:0]       xstep_q, ystep_q;
  logic [NW-1:0]                       max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= jet_pkg::LEFT_EDGE_RST;
      bottom_q   <= jet_pkg::BOTTOM_EDGE_RST;
      xstep_q    <= jet_pkg::X_STEP_RST;
      ystep_q    <= jet_pkg::Y_STEP_RST;
      max_iter_q <= jet_pkg::MAX_ITER_RST;
      c_re_q     <= jet_pkg::C_REAL_RST;
      c_im_q     <= jet_pkg::C_IMAG_RST;
    end else if (cfg_we_i) begin
      unique case (jet_pkg::cfg_reg_e'(cfg_index_i))
        jet_pkg::REG_LEFT_EDGE:   left_q     <= cfg_data_i[CW-1:0];
        jet_pkg::REG_BOTTOM_EDGE: bottom_q   <= cfg_data_i[CW-1:0];
        jet_pkg::REG_X_STEP:      xstep_q    <= cfg_data_i[jet_pkg::STEP_BITS-1:0];
        jet_pkg::REG_Y_STEP:      ystep_q    <= cfg_data_i[jet_pkg::STEP_BITS-1:0];
        jet_pkg::REG_MAX_ITER:    max_iter_q <= cfg_data_i[NW-1:0];
        jet_pkg::REG_C_REAL:      c_re_q     <= cfg_data_i[CW-1:0];
        jet_pkg::REG_C_IMAG:      c_im_q     <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // start point
  logic [PW-1:0]        px_d, py_d, px_q, py_q;
  logic signed [WW-1:0] sre_sum, sim_sum;
  logic signed [CW-1:0] sre_d, sim_d;

  assign px_d    = pixel_i.column * xstep_q;
  assign py_d    = pixel_i.row * ystep_q;
  assign sre_sum = {{(WW-CW){left_q[CW-1]}}, left_q} + {{(WW-PW){1'b0}}, px_q};
  assign sim_sum = {{(WW-CW){bottom_q[CW-1]}}, bottom_q} + {{(WW-PW){1'b0}}, py_q};
  assign sre_d   = sat32(sre_sum);
  assign sim_d   = sat32(sim_sum);

  // iteration
  logic signed [CW-1:0] x_q, y_q, sre_q, sim_q;
  logic signed [WW-1:0] xx_d, yy_d, xy_d, xx_q, yy_q, xy_q;
  logic signed [WW-1:0] diff, re_sh, im_sh, re_sum, im_sum;
  logic signed [CW-1:0] nre, nim;
  logic [WW-1:0]        mag;
  logic [NW-1:0]        count_q, count_inc;

  assign xx_d = x_q * x_q;
  assign yy_d = y_q * y_q;
  assign xy_d = x_q * y_q;

  // arithmetic shift right is floor division by the power of two
  assign diff   = xx_q - yy_q;
  assign re_sh  = diff >>> FRAC_BITS;
  assign im_sh  = xy_q >>> (FRAC_BITS - 1);
  assign re_sum = re_sh + {{(WW-CW){c_re_q[CW-1]}}, c_re_q};
  assign im_sum = im_sh + {{(WW-CW){c_im_q[CW-1]}}, c_im_q};
  assign nre    = sat32(re_sum);
  assign nim    = sat32(im_sum);

  // squares of the current z, never above 2^63
  assign mag       = xx_q + yy_q;
  assign count_inc = count_q + NW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= px_d;
      py_q <= py_d;
    end
    if (cmd_i.init) begin
      x_q     <= sre_d;
      y_q     <= sim_d;
      sre_q   <= sre_d;
      sim_q   <= sim_d;
      count_q <= '0;
    end
    if (cmd_i.mul) begin
      xx_q <= xx_d;
      yy_q <= yy_d;
      xy_q <= xy_d;
    end
    if (cmd_i.count_inc) begin
      count_q <= count_inc;
    end
    if (cmd_i.advance) begin
      x_q <= nre;
      y_q <= nim;
    end
  end

  assign sts_o.limit_zero = (max_iter_q == '0);
  assign sts_o.escape     = EscEn && (mag > Thresh);
  assign sts_o.last       = (count_inc == max_iter_q);

  assign result_o.start_re     = sre_q;
  assign result_o.start_im     = sim_q;
  assign result_o.escape_count = count_q;

endmodule

`default_nettype wire

// ----- tb/sv/julia_escape_time_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for julia_escape_time: pixel beats go in, every result beat is
// compared with an in-bench orbit predictor kept by a small scoreboard class
// depends on jet_pkg and the julia_escape_time rtl
module julia_escape_time_tb;

  localparam int FRAC_BITS = 28;
  localparam int unsigned WATCHDOG_CYCLES = 5_000_000;
  // |z|^2 > 4 in the squared scale; out of reach when the shift leaves 64 bits
  localparam longint unsigned ESCAPE_BOUND =
    (2 * FRAC_BITS + 2 < 64) ? (64'd1 << (2 * FRAC_BITS + 2)) : '1;

  class escape_scoreboard;
    jet_pkg::jet_out_t expected_points[$];
    int unsigned       errors;
    longint            left_edge, bottom_edge, x_step, y_step, c_re, c_im;
    longint unsigned   iter_limit;

    function new();
      left_edge   = longint'(jet_pkg::LEFT_EDGE_RST);
      bottom_edge = longint'(jet_pkg::BOTTOM_EDGE_RST);
      x_step      = longint'(jet_pkg::X_STEP_RST);
      y_step      = longint'(jet_pkg::Y_STEP_RST);
      iter_limit  = 64'(jet_pkg::MAX_ITER_RST);
      c_re        = longint'(jet_pkg::C_REAL_RST);
      c_im        = longint'(jet_pkg::C_IMAG_RST);
      errors      = 0;
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void apply_reg(logic [jet_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [jet_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        jet_pkg::REG_LEFT_EDGE:   left_edge   = longint'($signed(data));
        jet_pkg::REG_BOTTOM_EDGE: bottom_edge = longint'($signed(data));
        jet_pkg::REG_X_STEP:      x_step      = longint'(data[jet_pkg::STEP_BITS-1:0]);
        jet_pkg::REG_Y_STEP:      y_step      = longint'(data[jet_pkg::STEP_BITS-1:0]);
        jet_pkg::REG_MAX_ITER:    iter_limit  = 64'(data[jet_pkg::COUNT_BITS-1:0]);
        jet_pkg::REG_C_REAL:      c_re        = longint'($signed(data));
        jet_pkg::REG_C_IMAG:      c_im        = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function jet_pkg::jet_out_t trace_orbit(jet_pkg::jet_in_t px);
      jet_pkg::jet_out_t res;
      longint            x, y, nx, ny;
      longint unsigned   n, mag;
      x = clamp32(left_edge + longint'(px.column) * x_step);
      y = clamp32(bottom_edge + longint'(px.row) * y_step);
      res.start_re = x[31:0];
      res.start_im = y[31:0];
      n = 0;
      while (n < iter_limit) begin
        nx = clamp32(((x * x - y * y) >>> FRAC_BITS) + c_re);
        ny = clamp32(((x * y) >>> (FRAC_BITS - 1)) + c_im);
        x = nx;
        y = ny;
        mag = $unsigned(x * x) + $unsigned(y * y);
        if (mag > ESCAPE_BOUND) break;
        n++;
      end
      res.escape_count = n[jet_pkg::COUNT_BITS-1:0];
      return res;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    function void note_pixel(jet_pkg::jet_in_t px);
      expected_points.push_back(trace_orbit(px));
    endfunction

    function void check_result(jet_pkg::jet_out_t got);
      jet_pkg::jet_out_t want;
      if (expected_points.size() == 0) begin
        flag($sformatf("result beat with no pixel outstanding: re %0d im %0d count %0d",
                       got.start_re, got.start_im, got.escape_count));
        return;
      end
      want = expected_points.pop_front();
      if (got.start_re !== want.start_re || got.start_im !== want.start_im ||
          got.escape_count !== want.escape_count)
        flag($sformatf("re %0d/%0d im %0d/%0d count %0d/%0d (expected/actual)",
                       want.start_re, got.start_re, want.start_im, got.start_im,
                       want.escape_count, got.escape_count));
    endfunction
  endclass

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              start       = 1'b0;
  jet_pkg::jet_in_t                  pixel_i     = '0;
  logic                              cfg_valid_i = 1'b0;
  logic [jet_pkg::CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [jet_pkg::CFG_DATA_BITS-1:0] cfg_data_i  = '0;
  logic                              busy, cfg_ready_o, done_o;
  jet_pkg::jet_out_t                 result_o;

  escape_scoreboard sb = new();
  int unsigned      sender_idle_pct = 0;
  int unsigned      cycle_count = 0;

  julia_escape_time #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i, .rst_ni, .start, .busy, .pixel_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .done_o, .result_o
  );

  always #6 clk_i = ~clk_i;

  // the receiver cannot stall: every strobed beat is taken at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) sb.check_result(result_o);
  end

  // start stays high after the accepting edge so a back-to-back beat needs no toggle
  task automatic send_pixel(input int unsigned col, input int unsigned row);
    jet_pkg::jet_in_t px;
    px.column = jet_pkg::INDEX_BITS'(col);
    px.row    = jet_pkg::INDEX_BITS'(row);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(px);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || sb.expected_points.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // writes every register, then the spare index, which the block must drop
  task automatic program_view(input logic [31:0] left, input logic [31:0] bottom,
                              input logic [31:0] xs, input logic [31:0] ys,
                              input logic [31:0] lim, input logic [31:0] cre,
                              input logic [31:0] cim);
    logic [jet_pkg::CFG_DATA_BITS-1:0] vals [8];
    vals = '{left, bottom, xs, ys, lim, cre, cim, $urandom()};
    settle();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= jet_pkg::CFG_IDX_BITS'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.apply_reg(jet_pkg::CFG_IDX_BITS'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    while (cycle_count < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned idle_modes [4];
    int          xs, ys;
    idle_modes = '{0, 65, 0, 24};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // reset view: corners other than (0, 0) saturate, origin and 1.0 never escape, 2.0 escapes at once
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(512, 512);
    send_pixel(768, 512);
    send_pixel(1024, 512);
    send_pixel(2048, 2048);

    // upper data bits of the limit are dropped, so the limit is zero here
    program_view(jet_pkg::LEFT_EDGE_RST, jet_pkg::BOTTOM_EDGE_RST, jet_pkg::X_STEP_RST,
                 jet_pkg::Y_STEP_RST, 32'hFFFF_0000, jet_pkg::C_REAL_RST,
                 jet_pkg::C_IMAG_RST);
    send_pixel(100, 200);
    send_pixel(4095, 4095);

    // coordinate and constant extremes
    program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                 32'd3, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(1, 4095);
    send_pixel(4095, 1);

    // full count range: the origin never escapes under c = 0
    program_view(jet_pkg::LEFT_EDGE_RST, jet_pkg::BOTTOM_EDGE_RST, jet_pkg::X_STEP_RST,
                 jet_pkg::Y_STEP_RST, 32'h0000_FFFF, jet_pkg::C_REAL_RST,
                 jet_pkg::C_IMAG_RST);
    send_pixel(512, 512);

    for (int ph = 0; ph < 8; ph++) begin
      sender_idle_pct = idle_modes[ph % 4];
      if (ph % 4 == 3) begin
        program_view($urandom(), $urandom(), $urandom(), $urandom(),
                     {16'($urandom()), 16'($urandom_range(0, 48))}, $urandom(), $urandom());
      end else begin
        // a window of about +-1 to +-4 around the origin with both parts of c in [-1, 1]
        xs = $urandom_range(1 << 17, 1 << 19);
        ys = $urandom_range(1 << 17, 1 << 19);
        program_view(xs * -2048 + $urandom_range(0, 1 << 20) - (1 << 19),
                     ys * -2048 + $urandom_range(0, 1 << 20) - (1 << 19),
                     xs, ys, $urandom_range(1, 255),
                     $urandom_range(0, 1 << 29) - (1 << 28),
                     $urandom_range(0, 1 << 29) - (1 << 28));
      end
      repeat (80) send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_points.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/jet_pkg.sv
hw/rtl/jet_ctrl.sv
hw/rtl/jet_dp.sv
hw/rtl/julia_escape_time.sv
tb/sv/julia_escape_time_tb.sv
